>>> rtl/bpt_pkg.sv
// Package for the bimodal branch predictor with a target table.
// Holds table sizing, counter thresholds, action codes and the request type.
// No dependencies.
package bpt_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] CTR_MAX = 2'd3;
	localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;

	localparam logic ACT_PREDICT = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef struct packed {
		logic             action;
		logic [IDX_W-1:0] idx;
		logic [31:0]      target;
		logic             pred;
		logic             actual;
	} req_t;

endpackage

>>> rtl/bpt_front.sv
// Front part of the predictor: accepts requests and turns them into queue entries.
// Depends on bpt_pkg.
module bpt_front
	import bpt_pkg::*;
(
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [31:0] branch_pc,
	input  logic [31:0] branch_target,
	input  logic        was_predicted_taken,
	input  logic        actually_taken,
	input  logic        clearing,
	input  logic        q_full,
	output logic        push,
	output req_t        push_req
);

	always_comb begin
		busy = clearing | q_full;
		push = start & ~busy;
		push_req.action = action;
		push_req.idx = branch_pc[IDX_W+1:2];
		push_req.target = (action == ACT_UPDATE) ? branch_target : 32'd0;
		push_req.pred = (action == ACT_UPDATE) ? was_predicted_taken : 1'b0;
		push_req.actual = (action == ACT_UPDATE) ? actually_taken : 1'b0;
	end

endmodule

>>> rtl/bpt_queue.sv
// Short request queue between the front and back parts of the predictor.
// Depends on bpt_pkg.
module bpt_queue
	import bpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	input  logic pop,
	output req_t head,
	output logic full,
	output logic empty
);

	req_t              q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full = (cnt_q == QUEUE_DEPTH[QPTR_W:0]);
	assign empty = (cnt_q == '0);
	assign head = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/bpt_back.sv
// Back part of the predictor: direction and target tables, statistics and results.
// Depends on bpt_pkg.
module bpt_back
	import bpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  req_t        head,
	output logic        pop,
	output logic        clearing,
	output logic        done,
	output logic        predict_taken,
	output logic        flush,
	output logic [31:0] lookups_total,
	output logic [31:0] taken_predictions,
	output logic [31:0] mispredicts_total,
	output logic [31:0] direction_mispredicts,
	output logic [31:0] target_mispredicts
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0]       ctr_mem [TABLE_ENTRIES];
	logic [31:0]      tgt_mem [TABLE_ENTRIES];
	logic [1:0]       ctr_rd_q;
	logic [31:0]      tgt_rd_q;
	logic [1:0]       state_q;
	logic [IDX_W-1:0] clr_idx_q;
	req_t             item_s1;
	logic             done_q;
	logic             taken_q;
	logic             flush_q;
	logic [31:0]      lookup_cnt_q;
	logic [31:0]      taken_cnt_q;
	logic [31:0]      mispred_cnt_q;
	logic [31:0]      dir_miss_cnt_q;
	logic [31:0]      tgt_miss_cnt_q;

	logic             exec;
	logic             is_pred;
	logic             pred_taken;
	logic             tgt_diff;
	logic             tgt_miss;
	logic             dir_miss;
	logic [1:0]       ctr_next;
	logic             ctr_we;
	logic             tgt_we;
	logic [IDX_W-1:0] wr_idx;
	logic [1:0]       ctr_wdata;
	logic [31:0]      tgt_wdata;

	always_comb begin
		exec = (state_q == ST_EXEC);
		clearing = (state_q == ST_CLEAR);
		pop = (state_q == ST_IDLE) && !q_empty;
		is_pred = (item_s1.action == ACT_PREDICT);
		pred_taken = (ctr_rd_q >= CTR_TAKEN_MIN);
		tgt_diff = (tgt_rd_q != item_s1.target);
		tgt_miss = item_s1.pred && item_s1.actual && tgt_diff;
		dir_miss = (item_s1.pred != item_s1.actual);
		if (item_s1.actual) begin
			ctr_next = (ctr_rd_q == CTR_MAX) ? ctr_rd_q : ctr_rd_q + 2'd1;
		end else begin
			ctr_next = (ctr_rd_q == 2'd0) ? ctr_rd_q : ctr_rd_q - 2'd1;
		end
		ctr_we = clearing || (exec && !is_pred);
		tgt_we = clearing
			|| (exec && !is_pred && item_s1.actual && (!item_s1.pred || tgt_diff));
		wr_idx = clearing ? clr_idx_q : item_s1.idx;
		ctr_wdata = clearing ? 2'd0 : ctr_next;
		tgt_wdata = clearing ? 32'd0 : item_s1.target;
	end

	always_ff @(posedge clk) begin
		if (ctr_we) begin
			ctr_mem[wr_idx] <= ctr_wdata;
		end
		if (tgt_we) begin
			tgt_mem[wr_idx] <= tgt_wdata;
		end
		if (pop) begin
			ctr_rd_q <= ctr_mem[head.idx];
			tgt_rd_q <= tgt_mem[head.idx];
			item_s1 <= head;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			taken_q <= is_pred && pred_taken;
			flush_q <= !is_pred && tgt_miss;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_idx_q <= '0;
			done_q <= 1'b0;
			lookup_cnt_q <= '0;
			taken_cnt_q <= '0;
			mispred_cnt_q <= '0;
			dir_miss_cnt_q <= '0;
			tgt_miss_cnt_q <= '0;
		end else begin
			done_q <= exec;
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (is_pred) begin
						lookup_cnt_q <= lookup_cnt_q + 32'd1;
						if (pred_taken) begin
							taken_cnt_q <= taken_cnt_q + 32'd1;
						end
					end else begin
						if (dir_miss || tgt_miss) begin
							mispred_cnt_q <= mispred_cnt_q + 32'd1;
						end
						if (dir_miss) begin
							dir_miss_cnt_q <= dir_miss_cnt_q + 32'd1;
						end
						if (tgt_miss) begin
							tgt_miss_cnt_q <= tgt_miss_cnt_q + 32'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign predict_taken = taken_q;
	assign flush = flush_q;
	assign lookups_total = lookup_cnt_q;
	assign taken_predictions = taken_cnt_q;
	assign mispredicts_total = mispred_cnt_q;
	assign direction_mispredicts = dir_miss_cnt_q;
	assign target_mispredicts = tgt_miss_cnt_q;

	a_pop_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_EXEC))
		else $error("popped request did not reach execution");
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("result strobe without an executed request");
	a_flush_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(flush && predict_taken))
		else $error("flush and taken prediction in one result");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop)
		else $error("request taken during table clear");
	a_stats_stable: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> $stable(lookup_cnt_q) && $stable(mispred_cnt_q))
		else $error("statistics moved while a result was shown");

endmodule

>>> rtl/bimodal_predictor_with_target_table.sv
// Top level of the bimodal branch predictor with a branch target table.
// Depends on bpt_pkg, bpt_front, bpt_queue and bpt_back.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low. action selects a predict lookup or a resolve update; the table entry is
// chosen by the word address of branch_pc modulo the table size.
// Each request yields one result, shown on the result ports for exactly one
// cycle while done is high. The receiver cannot stall; it must take the
// result in that cycle.
// When the queue is empty, an accepted request is stored in the queue, popped
// with both tables read in ST_IDLE, then executed in ST_EXEC (table update and
// result), which raises done. The back end pops only in ST_IDLE, so it does not
// take the next request until the current one has been executed.
// The two-entry request queue lets the front keep accepting while the back
// works; busy is high while the queue is full.
// After reset the tables are cleared one entry per cycle, all TABLE_ENTRIES
// (1024) of them, with busy held high; all statistics start at zero.
module bimodal_predictor_with_target_table
	import bpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [31:0] branch_pc,
	input  logic [31:0] branch_target,
	input  logic        was_predicted_taken,
	input  logic        actually_taken,
	output logic        done,
	output logic        predict_taken,
	output logic        flush,
	output logic [31:0] lookups_total,
	output logic [31:0] taken_predictions,
	output logic [31:0] mispredicts_total,
	output logic [31:0] direction_mispredicts,
	output logic [31:0] target_mispredicts
);

	logic clearing;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	req_t push_req;
	req_t head;

	bpt_front u_front (
		.start               (start),
		.busy                (busy),
		.action              (action),
		.branch_pc           (branch_pc),
		.branch_target       (branch_target),
		.was_predicted_taken (was_predicted_taken),
		.actually_taken      (actually_taken),
		.clearing            (clearing),
		.q_full              (q_full),
		.push                (push),
		.push_req            (push_req)
	);

	bpt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	bpt_back u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.q_empty               (q_empty),
		.head                  (head),
		.pop                   (pop),
		.clearing              (clearing),
		.done                  (done),
		.predict_taken         (predict_taken),
		.flush                 (flush),
		.lookups_total         (lookups_total),
		.taken_predictions     (taken_predictions),
		.mispredicts_total     (mispredicts_total),
		.direction_mispredicts (direction_mispredicts),
		.target_mispredicts    (target_mispredicts)
	);

endmodule

>>> bench/tb_bimodal_predictor_with_target_table.sv
`timescale 1ns / 100ps
// Self-checking bench for bimodal_predictor_with_target_table: a directed table
// followed by random predict/update traffic, checked against an in-bench model.
// Depends on bpt_pkg and the predictor RTL.
module tb_bimodal_predictor_with_target_table;
	import bpt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 1400;
	localparam int SCRIPT_LEN = 19;

	typedef struct packed {
		logic        predict_taken;
		logic        flush;
		logic [31:0] lookups;
		logic [31:0] taken;
		logic [31:0] mispredicts;
		logic [31:0] dir_misses;
		logic [31:0] tgt_misses;
	} result_t;

	typedef struct packed {
		logic        action;
		logic [31:0] pc;
		logic [31:0] target;
		logic        pred;
		logic        actual;
		logic        typed_in;
		result_t     want;
	} branch_req_t;

	localparam result_t NO_CHECK = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        action = ACT_PREDICT;
	logic [31:0] branch_pc = '0;
	logic [31:0] branch_target = '0;
	logic        was_predicted_taken = 1'b0;
	logic        actually_taken = 1'b0;
	logic        busy;
	logic        done;
	logic        predict_taken;
	logic        flush;
	logic [31:0] lookups_total;
	logic [31:0] taken_predictions;
	logic [31:0] mispredicts_total;
	logic [31:0] direction_mispredicts;
	logic [31:0] target_mispredicts;

	logic [1:0]  dir_ctr [TABLE_ENTRIES];
	logic [31:0] tgt_table [TABLE_ENTRIES];
	logic [31:0] lookup_tally = '0;
	logic [31:0] taken_tally = '0;
	logic [31:0] mispredict_tally = '0;
	logic [31:0] dir_miss_tally = '0;
	logic [31:0] tgt_miss_tally = '0;

	result_t pending_results [$];
	int      fail_count = 0;
	int      cycle_count = 0;

	branch_req_t script [SCRIPT_LEN] = '{
		'{ACT_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1,
			'{1'b0, 1'b0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{ACT_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b1,
			'{1'b0, 1'b0, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{ACT_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1,
			'{1'b0, 1'b0, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{ACT_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1,
			'{1'b0, 1'b0, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{ACT_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
			'{1'b0, 1'b1, 32'd2, 32'd0, 32'd1, 32'd0, 32'd1}},
		'{ACT_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1,
			'{1'b1, 1'b0, 32'd3, 32'd1, 32'd1, 32'd0, 32'd1}},
		'{ACT_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
			'{1'b0, 1'b0, 32'd3, 32'd1, 32'd1, 32'd0, 32'd1}},
		'{ACT_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, NO_CHECK},
		'{ACT_PREDICT, 32'h0000_0002, 32'hDEAD_BEEF, 1'b1, 1'b1, 1'b0, NO_CHECK},
		'{ACT_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, NO_CHECK},
		'{ACT_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_CHECK},
		'{ACT_UPDATE, 32'hFFFF_FFFC, 32'h1234_5678, 1'b0, 1'b1, 1'b0, NO_CHECK},
		'{ACT_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, NO_CHECK},
		'{ACT_PREDICT, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b1, 1'b0, NO_CHECK},
		'{ACT_UPDATE, 32'h0000_1003, 32'h0000_0000, 1'b1, 1'b1, 1'b0, NO_CHECK},
		'{ACT_UPDATE, 32'hFFFF_FFFD, 32'h8765_4321, 1'b1, 1'b1, 1'b0, NO_CHECK},
		'{ACT_PREDICT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 1'b0, NO_CHECK},
		'{ACT_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1, 1'b0, NO_CHECK},
		'{ACT_PREDICT, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_CHECK}
	};

	bimodal_predictor_with_target_table i_dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.start                 (start),
		.busy                  (busy),
		.action                (action),
		.branch_pc             (branch_pc),
		.branch_target         (branch_target),
		.was_predicted_taken   (was_predicted_taken),
		.actually_taken        (actually_taken),
		.done                  (done),
		.predict_taken         (predict_taken),
		.flush                 (flush),
		.lookups_total         (lookups_total),
		.taken_predictions     (taken_predictions),
		.mispredicts_total     (mispredicts_total),
		.direction_mispredicts (direction_mispredicts),
		.target_mispredicts    (target_mispredicts)
	);

	always #5 clk = ~clk;

	function automatic logic [IDX_W-1:0] entry_of(input logic [31:0] pc);
		return IDX_W'((pc >> 2) % TABLE_ENTRIES);
	endfunction

	function automatic result_t apply_branch_request(input branch_req_t rq);
		result_t          res;
		logic [IDX_W-1:0] idx;
		res = '0;
		idx = entry_of(rq.pc);
		if (rq.action == ACT_PREDICT) begin
			lookup_tally = lookup_tally + 1;
			if (dir_ctr[idx] >= CTR_TAKEN_MIN) begin
				taken_tally = taken_tally + 1;
				res.predict_taken = 1'b1;
			end
		end else begin
			if (rq.actual && dir_ctr[idx] != CTR_MAX)
				dir_ctr[idx] = dir_ctr[idx] + 2'd1;
			else if (!rq.actual && dir_ctr[idx] != 2'd0)
				dir_ctr[idx] = dir_ctr[idx] - 2'd1;
			if (rq.pred != rq.actual) begin
				dir_miss_tally = dir_miss_tally + 1;
				mispredict_tally = mispredict_tally + 1;
			end
			if (rq.pred && rq.actual && tgt_table[idx] != rq.target) begin
				mispredict_tally = mispredict_tally + 1;
				tgt_miss_tally = tgt_miss_tally + 1;
				res.flush = 1'b1;
			end
			if (rq.actual && (!rq.pred || res.flush))
				tgt_table[idx] = rq.target;
		end
		res.lookups = lookup_tally;
		res.taken = taken_tally;
		res.mispredicts = mispredict_tally;
		res.dir_misses = dir_miss_tally;
		res.tgt_misses = tgt_miss_tally;
		return res;
	endfunction

	task automatic issue_request(input branch_req_t rq, input int gap);
		result_t want;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= rq.action;
		branch_pc <= rq.pc;
		branch_target <= rq.target;
		was_predicted_taken <= rq.pred;
		actually_taken <= rq.actual;
		do @(posedge clk); while (busy);
		want = apply_branch_request(rq);
		if (rq.typed_in)
			want = rq.want;
		pending_results.push_back(want);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("Result arrived with no request outstanding.");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("predict_taken", 32'(want.predict_taken), 32'(predict_taken));
				check_field("flush", 32'(want.flush), 32'(flush));
				check_field("lookups_total", want.lookups, lookups_total);
				check_field("taken_predictions", want.taken, taken_predictions);
				check_field("mispredicts_total", want.mispredicts, mispredicts_total);
				check_field("direction_mispredicts", want.dir_misses, direction_mispredicts);
				check_field("target_mispredicts", want.tgt_misses, target_mispredicts);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		branch_req_t rq;
		logic [31:0] pc_pool [16];
		logic [31:0] tgt_pool [16];
		int          bias [16];
		int          k;
		int          r;
		int          gap;
		for (int e = 0; e < TABLE_ENTRIES; e++) begin
			dir_ctr[e] = 2'd0;
			tgt_table[e] = '0;
		end
		for (int p = 0; p < 16; p++) begin
			pc_pool[p] = (p < 12) ? $urandom : pc_pool[p - 12] + 32'(TABLE_ENTRIES * 4);
			tgt_pool[p] = $urandom;
			bias[p] = $urandom_range(0, 100);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++)
			issue_request(script[i], $urandom_range(0, 10));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			k = $urandom_range(0, 15);
			r = $urandom_range(0, 99);
			rq = '0;
			rq.pc = pc_pool[k];
			rq.target = ($urandom_range(0, 3) == 0) ? tgt_pool[(k + 1) % 16] : tgt_pool[k];
			if (r < 40) begin
				rq.action = ACT_PREDICT;
				rq.pred = 1'($urandom_range(0, 1));
				rq.actual = 1'($urandom_range(0, 1));
			end else if (r < 85) begin
				rq.action = ACT_UPDATE;
				rq.pred = dir_ctr[entry_of(rq.pc)] >= CTR_TAKEN_MIN;
				if ($urandom_range(0, 9) == 0)
					rq.pred = !rq.pred;
				rq.actual = $urandom_range(0, 99) < bias[k];
			end else begin
				rq.action = 1'($urandom_range(0, 1));
				rq.pc = $urandom;
				rq.target = $urandom;
				rq.pred = 1'($urandom_range(0, 1));
				rq.actual = 1'($urandom_range(0, 1));
			end
			gap = ((n / 100) % 3 == 0) ? 0 : $urandom_range(0, 10);
			issue_request(rq, gap);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
rtl/bpt_pkg.sv
rtl/bpt_front.sv
rtl/bpt_queue.sv
rtl/bpt_back.sv
rtl/bimodal_predictor_with_target_table.sv
bench/tb_bimodal_predictor_with_target_table.sv
